// ===== rtl/u8u16_pkg.sv =====
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PointW = 21;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned RemW   = 2;

  // Lead byte patterns: the byte matches when (byte & mask) == code.
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;

  // Continuations still expected after each kind of lead byte.
  localparam logic [RemW-1:0] RemNone  = 2'd0;
  localparam logic [RemW-1:0] RemLead2 = 2'd1;
  localparam logic [RemW-1:0] RemLead3 = 2'd2;
  localparam logic [RemW-1:0] RemLead4 = 2'd3;

  localparam logic [PointW-1:0] SuppBase = 21'h10000;
  localparam logic [UnitW-1:0]  HighSurr = 16'hD800;
  localparam logic [UnitW-1:0]  LowSurr  = 16'hDC00;

  // One decoded request: whether it yields output, and the unit or the pair.
  typedef struct packed {
    logic             emit;
    logic             pair;
    logic [UnitW-1:0] unit_hi;
    logic [UnitW-1:0] unit_lo;
  } dec_res_t;

endpackage

// ===== rtl/u8u16_decode.sv =====
module u8u16_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_string_i,
  output u8u16_pkg::dec_res_t   res_o
);
  import u8u16_pkg::*;

  logic [PointW-1:0] acc_q, acc_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic              emit;
  logic [PointW-1:0] cp;
  logic [PointW-1:0] cp_off;

  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    emit  = 1'b0;
    cp    = '0;
    if (rem_q == RemNone) begin
      if ((data_byte_i & Lead2Mask) == Lead2Code) begin
        acc_d = {16'd0, data_byte_i[4:0]};
        rem_d = RemLead2;
      end else if ((data_byte_i & Lead3Mask) == Lead3Code) begin
        acc_d = {17'd0, data_byte_i[3:0]};
        rem_d = RemLead3;
      end else if ((data_byte_i & Lead4Mask) == Lead4Code) begin
        acc_d = {18'd0, data_byte_i[2:0]};
        rem_d = RemLead4;
      end else begin
        // Plain ASCII, stray continuation or invalid lead: the byte is the point.
        acc_d = '0;
        rem_d = RemNone;
        emit  = 1'b1;
        cp    = {13'd0, data_byte_i};
      end
      if (rem_d != RemNone && end_of_string_i) begin
        emit  = 1'b1;
        cp    = acc_d;
        acc_d = '0;
        rem_d = RemNone;
      end
    end else begin
      acc_d = {acc_q[PointW-7:0], data_byte_i[5:0]};
      rem_d = rem_q - 2'd1;
      if (rem_d == RemNone || end_of_string_i) begin
        emit  = 1'b1;
        cp    = acc_d;
        acc_d = '0;
        rem_d = RemNone;
      end
    end
  end

  assign cp_off = cp - SuppBase;

  always_comb begin
    res_o.emit = emit;
    res_o.pair = (cp[PointW-1:UnitW] != '0);
    if (res_o.pair) begin
      res_o.unit_hi = HighSurr + {5'd0, cp_off[PointW-1:10]};
      res_o.unit_lo = LowSurr + {6'd0, cp_off[9:0]};
    end else begin
      res_o.unit_hi = cp[UnitW-1:0];
      res_o.unit_lo = cp[UnitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= RemNone;
    end else if (step_i) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

endmodule

// ===== rtl/u8u16_out.sv =====
module u8u16_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  u8u16_pkg::dec_res_t   res_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           code_unit_o,
  output logic                  last_of_run_o
);
  import u8u16_pkg::*;

  logic             valid_q, valid_d;
  logic             phase_q, phase_d;
  logic [UnitW-1:0] hi_q, lo_q;
  logic             fire;

  // phase_q is set while the high half of a surrogate pair is on the port.
  assign fire          = valid_q && !out_stall_i;
  assign free_o        = !valid_q || (fire && !phase_q);
  assign out_valid_o   = valid_q;
  assign code_unit_o   = phase_q ? hi_q : lo_q;
  assign last_of_run_o = !phase_q;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    if (fire && phase_q) begin
      phase_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
      phase_d = res_i.pair;
    end else if (fire && !phase_q) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hi_q <= res_i.unit_hi;
      lo_q <= res_i.unit_lo;
    end
  end

endmodule

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder.
// Input channel: one UTF-8 byte per request (data_byte_i) with end_of_string_i
// set on the last byte of a string. A request is taken when in_valid_i is high
// and in_stall_o is low.
// Output channel: one UTF-16 unit per request (code_unit_o); last_of_run_o marks
// the final unit produced by an input byte. A supplementary code point gives a
// surrogate pair, high half first, on two consecutive output requests.
// A taken byte is registered; the unit it yields is registered at the output.
// Throughput: one byte per cycle unless stalled; after a surrogate pair, the
// next byte that yields a unit waits in the input register while the low half
// is sent, as the output register sends at most one unit per cycle. Lead and
// middle bytes that do not end a string produce nothing and never wait on the
// output. When the receiver stalls, the output unit holds; the input register
// keeps decoding bytes that produce no units, and in_stall_o rises once a byte
// that needs an output slot is waiting.
// Reset clears the input and output valid flags and closes any open sequence.
module utf8_to_utf16_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        last_of_run_o
);
  import u8u16_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] byte_q;
  logic             eos_q;
  logic             accept;
  logic             advance;
  logic             out_free;
  dec_res_t         res;

  // The registered byte moves on when it yields nothing or the output has room.
  assign advance    = in_valid_q && (!res.emit || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      eos_q  <= end_of_string_i;
    end
  end

  u8u16_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .data_byte_i     (byte_q),
    .end_of_string_i (eos_q),
    .res_o           (res)
  );

  u8u16_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && res.emit),
    .res_i         (res),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_unit_o   (code_unit_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== rtl/u8u16_checker.sv =====
module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        end_of_string_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] code_unit_o,
  input logic        last_of_run_o
);

  // A stalled output request stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  // A stalled output request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(code_unit_o) && $stable(last_of_run_o))
    else $error("output payload changed while stalled");

  // A unit that is not the last of its byte is a high half. Points past the
  // Unicode range push it above DBFF, but it stays within D800 to DFFF.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> code_unit_o[15:11] == 5'b11011)
    else $error("non-final unit is not a high surrogate");

  // Once the high half is taken, the low surrogate is on the port in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=>
      out_valid_o && last_of_run_o && code_unit_o[15:10] == 6'b110111)
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (.*);
